@@ hw/rtl/mkcd_pkg.sv @@
// ----------------------------------------------------------------------------
// mkcd_pkg: shared types and constants of the multi-key click detector
// Beat formats, configuration register map, event flag encoding and the
// control groups passed between the top level and the per-key lanes.
// ----------------------------------------------------------------------------
package mkcd_pkg;

    // field widths
    localparam int KEY_BITS   = 4;
    localparam int QKEY_W     = 2;
    localparam int EV_W       = 7;
    localparam int CD_W       = 16;
    localparam int PER_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // default key count
    localparam int NUM_KEYS_DEF = 4;

    // event flag bit positions
    localparam int EV_DOWN_BIT   = 0;
    localparam int EV_UP_BIT     = 1;
    localparam int EV_HOLD_BIT   = 2;
    localparam int EV_SINGLE_BIT = 3;
    localparam int EV_DOUBLE_BIT = 4;
    localparam int EV_LONG_BIT   = 5;
    localparam int EV_REPEAT_BIT = 6;

    // a mask of exactly hold is a peek and clears nothing
    localparam logic [EV_W-1:0] EV_HOLD_MASK = EV_W'(1) << EV_HOLD_BIT;

    // configuration reset values
    localparam logic              DBL_EN_RST = 1'b0;
    localparam logic [PER_W-1:0]  PERIOD_RST = PER_W'(20);
    localparam logic [CD_W-1:0]   WINDOW_RST = CD_W'(300);
    localparam logic [CD_W-1:0]   LONG_RST   = CD_W'(1600);
    localparam logic [CD_W-1:0]   REPEAT_RST = CD_W'(100);

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DBL_EN = 3'd0,
        CFG_PERIOD = 3'd1,
        CFG_WINDOW = 3'd2,
        CFG_LONG   = 3'd3,
        CFG_REPEAT = 3'd4
    } cfg_idx_t;

    // operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // input beat
    typedef struct packed {
        logic                op;
        logic [KEY_BITS-1:0] keys_pressed;
        logic [QKEY_W-1:0]   query_key;
        logic [EV_W-1:0]     event_mask;
    } in_beat_t;

    // output beat
    typedef struct packed {
        logic            hit;
        logic [EV_W-1:0] key_flags;
    } out_beat_t;

    // timing configuration seen by every lane
    typedef struct packed {
        logic            dbl_en;
        logic [CD_W-1:0] window;
        logic [CD_W-1:0] long_press;
        logic [CD_W-1:0] repeat_ivl;
    } lane_cfg_t;

    // per-beat lane control
    typedef struct packed {
        logic tick;
        logic sample;
        logic check;
    } lane_ctrl_t;

endpackage

@@ hw/rtl/multi_key_click_detector.sv @@
// ----------------------------------------------------------------------------
// multi_key_click_detector: debounced per-key button event detector
// Tick beats sample key levels every sample period and drive per-key click
// state machines; check beats read and clear one key's event flags.
// ----------------------------------------------------------------------------
// Throughput is one beat per clock while out_ready is high: every key has its
// own lane that updates in the cycle its beat is accepted, and the result
// appears in the output register on the next cycle. The input is ready whenever
// the output register is empty or its beat is taken in the same cycle, so a full
// pipeline runs without bubbles. Ticks always return hit = 0 and zero flags.
// Configuration writes take effect at the write edge and need no handshake.
// ----------------------------------------------------------------------------
module multi_key_click_detector
    import mkcd_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic             dbl_en_reg;
    logic [PER_W-1:0] period_reg;
    logic [CD_W-1:0]  window_reg;
    logic [CD_W-1:0]  long_reg;
    logic [CD_W-1:0]  repeat_reg;

    logic [PER_W-1:0] tick_cnt_reg, tick_cnt_next;
    logic [PER_W-1:0] tick_inc;

    logic             out_valid_reg;
    out_beat_t        out_data_reg;

    logic             accept;
    logic             is_tick;
    logic             is_check;
    logic             do_sample;
    lane_cfg_t        lcfg;
    logic [EV_W-1:0]  lane_flags [NUM_KEYS];
    logic [NUM_KEYS-1:0] lane_sel;
    out_beat_t        check_result;

    // handshake
    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign is_tick  = accept && (in_data.op == OP_TICK);
    assign is_check = accept && (in_data.op == OP_CHECK);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbl_en_reg <= DBL_EN_RST;
            period_reg <= PERIOD_RST;
            window_reg <= WINDOW_RST;
            long_reg   <= LONG_RST;
            repeat_reg <= REPEAT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DBL_EN: dbl_en_reg <= cfg_data[0];
                CFG_PERIOD: period_reg <= cfg_data[PER_W-1:0];
                CFG_WINDOW: window_reg <= cfg_data[CD_W-1:0];
                CFG_LONG:   long_reg   <= cfg_data[CD_W-1:0];
                CFG_REPEAT: repeat_reg <= cfg_data[CD_W-1:0];
                default:    ;
            endcase
        end
    end

    assign lcfg.dbl_en     = dbl_en_reg;
    assign lcfg.window     = window_reg;
    assign lcfg.long_press = long_reg;
    assign lcfg.repeat_ivl = repeat_reg;

    // sampling divider
    assign tick_inc  = tick_cnt_reg + PER_W'(1);
    assign do_sample = (tick_inc >= period_reg);

    always_comb
    begin
        tick_cnt_next = tick_cnt_reg;
        if (is_tick)
        begin
            tick_cnt_next = do_sample ? '0 : tick_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_cnt_reg <= '0;
        end
        else
        begin
            tick_cnt_reg <= tick_cnt_next;
        end
    end

    // per-key lanes
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        logic       lvl;
        lane_ctrl_t ctrl;

        if (k < KEY_BITS)
        begin : g_pin
            assign lvl = in_data.keys_pressed[k];
        end
        else
        begin : g_nopin
            assign lvl = 1'b0;
        end

        assign ctrl.tick   = is_tick;
        assign ctrl.sample = do_sample;
        assign ctrl.check  = is_check && lane_sel[k];

        mkcd_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg        (lcfg),
            .ctrl       (ctrl),
            .level      (lvl),
            .event_mask (in_data.event_mask),
            .flags      (lane_flags[k])
        );
    end

    // lane select and result merge
    mkcd_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .lane_flags (lane_flags),
        .query_key  (in_data.query_key),
        .event_mask (in_data.event_mask),
        .lane_sel   (lane_sel),
        .result     (check_result)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= (in_data.op == OP_CHECK) ? check_result : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/mkcd_lane.sv @@
// ----------------------------------------------------------------------------
// mkcd_lane: event detector for one key
// Holds the key's sampled levels, click state, countdown timer and event
// flags; advances on ticks and clears requested flags on checks.
// ----------------------------------------------------------------------------
module mkcd_lane
    import mkcd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  lane_cfg_t       cfg,
    input  lane_ctrl_t      ctrl,
    input  logic            level,
    input  logic [EV_W-1:0] event_mask,
    output logic [EV_W-1:0] flags
);

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_PRESSED = 5'b00010,
        ST_WAIT2   = 5'b00100,
        ST_HELD2   = 5'b01000,
        ST_LONG    = 5'b10000
    } click_state_t;

    click_state_t    state_reg, state_next;
    logic [CD_W-1:0] cd_reg, cd_next;
    logic [EV_W-1:0] flags_reg, flags_next;
    logic            lvl_now_reg, lvl_now_next;
    logic            lvl_bef_reg, lvl_bef_next;
    logic [CD_W-1:0] cd_dec;

    // saturating countdown
    assign cd_dec = (cd_reg != '0) ? cd_reg - CD_W'(1) : '0;

    // next-state logic
    always_comb
    begin
        state_next   = state_reg;
        cd_next      = cd_reg;
        flags_next   = flags_reg;
        lvl_now_next = lvl_now_reg;
        lvl_bef_next = lvl_bef_reg;
        if (ctrl.tick)
        begin
            cd_next = cd_dec;
            if (ctrl.sample)
            begin
                lvl_bef_next = lvl_now_reg;
                lvl_now_next = level;
                flags_next[EV_HOLD_BIT] = level;
                if (level && !lvl_now_reg)
                begin
                    flags_next[EV_DOWN_BIT] = 1'b1;
                end
                if (!level && lvl_now_reg)
                begin
                    flags_next[EV_UP_BIT] = 1'b1;
                end
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (level)
                        begin
                            cd_next    = cfg.long_press;
                            state_next = ST_PRESSED;
                        end
                    end
                    ST_PRESSED:
                    begin
                        if (!level)
                        begin
                            if (cfg.dbl_en)
                            begin
                                cd_next    = cfg.window;
                                state_next = ST_WAIT2;
                            end
                            else
                            begin
                                flags_next[EV_SINGLE_BIT] = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else if (cd_dec == '0)
                        begin
                            cd_next = cfg.repeat_ivl;
                            flags_next[EV_LONG_BIT] = 1'b1;
                            state_next = ST_LONG;
                        end
                    end
                    ST_WAIT2:
                    begin
                        if (level)
                        begin
                            flags_next[EV_DOUBLE_BIT] = 1'b1;
                            state_next = ST_HELD2;
                        end
                        else if (cd_dec == '0)
                        begin
                            flags_next[EV_SINGLE_BIT] = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    ST_HELD2:
                    begin
                        if (!level)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    ST_LONG:
                    begin
                        if (!level)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (cd_dec == '0)
                        begin
                            cd_next = cfg.repeat_ivl;
                            flags_next[EV_REPEAT_BIT] = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
        end
        else if (ctrl.check && ((flags_reg & event_mask) != '0)
                 && (event_mask != EV_HOLD_MASK))
        begin
            // read-and-clear of the requested bits
            flags_next = flags_reg & ~event_mask;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cd_reg      <= '0;
            flags_reg   <= '0;
            lvl_now_reg <= 1'b0;
            lvl_bef_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cd_reg      <= cd_next;
            flags_reg   <= flags_next;
            lvl_now_reg <= lvl_now_next;
            lvl_bef_reg <= lvl_bef_next;
        end
    end

    assign flags = flags_reg;

endmodule

@@ hw/rtl/mkcd_merge.sv @@
// ----------------------------------------------------------------------------
// mkcd_merge: lane select and result merge
// Decodes the queried key into a lane select and folds the lanes' flags
// into the check result.
// ----------------------------------------------------------------------------
module mkcd_merge
    import mkcd_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
)
(
    input  logic [EV_W-1:0]   lane_flags [NUM_KEYS],
    input  logic [QKEY_W-1:0] query_key,
    input  logic [EV_W-1:0]   event_mask,
    output logic [NUM_KEYS-1:0] lane_sel,
    output out_beat_t         result
);

    logic [EV_W-1:0] sel_flags;

    // one-hot lane select and or-merge of the selected flags
    always_comb
    begin
        sel_flags = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            lane_sel[k] = (int'(query_key) == k);
            if (lane_sel[k])
            begin
                sel_flags = sel_flags | lane_flags[k];
            end
        end
        result.key_flags = sel_flags;
        result.hit       = |(sel_flags & event_mask);
    end

endmodule
